FILE: design/rcmf_pkg.sv
// ----------------------------------------------------------------------------
// rcmf_pkg
// Shared constants and types of the recursive cross median filter: register
// map, register reset values, field widths and the configuration bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package rcmf_pkg;

  localparam int LINE_W     = 16;
  localparam int PPL_W      = 11;
  localparam int POS_W      = 10;
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 2;

  // register indexes, byte address is 4 * index
  localparam logic [REG_IDX_W-1:0] REG_LINE_COUNT  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_POSITIONS   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_FIRST_LINE  = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_FIRST_POS   = 2'd3;

  localparam logic [LINE_W-1:0] LINE_COUNT_RST = 16'd480;
  localparam logic [PPL_W-1:0]  POSITIONS_RST  = 11'd640;
  localparam logic [LINE_W-1:0] FIRST_LINE_RST = 16'd1;
  localparam logic [POS_W-1:0]  FIRST_POS_RST  = 10'd1;

  typedef struct packed {
    logic [LINE_W-1:0] line_count;
    logic [PPL_W-1:0]  positions_per_line;
    logic [LINE_W-1:0] first_filtered_line;
    logic [POS_W-1:0]  first_filtered_position;
  } cfg_t;

endpackage

`default_nettype wire

FILE: design/recursive_cross_median_filter.sv
// ----------------------------------------------------------------------------
// recursive_cross_median_filter
// Recursive five-point cross median filter over a line-by-line pixel stream.
// ----------------------------------------------------------------------------
// Pixels enter in raster order, one item per cycle. Inside the window a pixel
// becomes the median of itself, its right and lower raw neighbours and its
// left and upper filtered neighbours; elsewhere it passes unchanged. A pixel
// leaves with its coordinates when the pixel below it enters, so the first
// line gives no result and every pixel of the last line also goes out at
// once. An accepted item is held in the filter stage: the line memory read
// is registered at the accepting edge, and the median and write-back are
// done as the stage pushes its results into the result queue, which waits
// for room there. The rate is one item per cycle, set by the single read
// and write port of each line memory; the input stalls only while an item
// waits in the filter stage and the result queue lacks room for two. On the
// last line each item brings two results, and the one-result-per-cycle
// output sets the pace. The line memories start undefined and need no
// clearing after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module recursive_cross_median_filter #(
  parameter int MAX_POSITIONS = 1024,
  parameter int PIXEL_BITS    = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rcmf_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [rcmf_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [rcmf_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [PIXEL_BITS-1:0]             pixel_in,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [PIXEL_BITS-1:0]             pixel_out,
  output logic [rcmf_pkg::LINE_W-1:0]       line_index,
  output logic [rcmf_pkg::POS_W-1:0]        position_index,
  output logic                              end_of_run,
  output logic                              end_of_frame
);
  import rcmf_pkg::*;

  localparam int PW = $clog2(MAX_POSITIONS);
  localparam int RW = PIXEL_BITS + LINE_W + POS_W + 2;

  cfg_t cfg;

  // frame geometry
  logic [LINE_W-1:0] lines;
  logic [LINE_W-1:0] last_line;
  logic [LINE_W-1:0] start_line;
  logic [POS_W-1:0]  start_pos;
  logic [PPL_W-1:0]  npos;
  logic [PPL_W-1:0]  npos_m1;
  logic [PW-1:0]     last_pos;

  // input side
  logic [PW-1:0]     pos_cnt;
  logic [LINE_W-1:0] line_cnt;
  logic              accept;
  logic              is_last_line;
  logic              is_last_pos;
  logic              has_prev;
  logic [LINE_W-1:0] line_m1;
  logic              in_window;
  logic [PW-1:0]     raw_raddr;

  // filter stage
  logic                  s1_valid;
  logic [PIXEL_BITS-1:0] s1_pix;
  logic [PW-1:0]         s1_p;
  logic [LINE_W-1:0]     s1_line;
  logic                  s1_has_prev;
  logic                  s1_window;
  logic                  s1_last_line;
  logic                  s1_last_pos;
  logic                  s1_adv;
  logic [PIXEL_BITS-1:0] self_pix;
  logic [PIXEL_BITS-1:0] left_pix;
  logic [PIXEL_BITS-1:0] right_pix;
  logic [PIXEL_BITS-1:0] up_pix;
  logic [PIXEL_BITS-1:0] med;
  logic [PIXEL_BITS-1:0] fin;
  logic [POS_W-1:0]      s1_pos_out;
  logic [LINE_W-1:0]     s1_line_m1;

  // result queue
  logic          fifo_room;
  logic          push_a;
  logic          push_b;
  logic [RW-1:0] res_above;
  logic [RW-1:0] res_last;
  logic [RW-1:0] data_a;
  logic [RW-1:0] out_data;

  rcmf_cfg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  always_comb begin
    lines      = (cfg.line_count == '0) ? LINE_W'(1) : cfg.line_count;
    last_line  = lines - LINE_W'(1);
    start_line = (cfg.first_filtered_line == '0) ? LINE_W'(1) : cfg.first_filtered_line;
    start_pos  = (cfg.first_filtered_position == '0) ? POS_W'(1)
                                                     : cfg.first_filtered_position;
    npos       = (cfg.positions_per_line == '0) ? PPL_W'(1) : cfg.positions_per_line;
    npos_m1    = npos - PPL_W'(1);
    if (32'(cfg.positions_per_line) > MAX_POSITIONS) begin
      last_pos = PW'(MAX_POSITIONS - 1);
    end else begin
      last_pos = PW'(npos_m1);
    end
  end

  assign accept       = in_valid && in_ready;
  assign in_ready     = !s1_valid || fifo_room;
  assign is_last_line = (line_cnt >= last_line);
  assign is_last_pos  = (pos_cnt >= last_pos);
  assign has_prev     = (line_cnt != '0);
  assign line_m1      = line_cnt - LINE_W'(1);
  assign in_window    = has_prev && (line_m1 >= start_line) && (line_cnt < lines) &&
                        (LINE_W'(pos_cnt) >= LINE_W'(start_pos)) && (pos_cnt < last_pos);
  // at line end, fetch the first raw pixel of the line just completed
  assign raw_raddr    = is_last_pos ? '0 : pos_cnt + PW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_cnt  <= '0;
      line_cnt <= '0;
    end else if (accept) begin
      if (is_last_pos) begin
        pos_cnt  <= '0;
        line_cnt <= is_last_line ? '0 : line_cnt + LINE_W'(1);
      end else begin
        pos_cnt <= pos_cnt + PW'(1);
      end
    end
  end

  rcmf_line_store #(
    .DEPTH (MAX_POSITIONS),
    .AW    (PW),
    .W     (PIXEL_BITS)
  ) u_store (
    .clk       (clk),
    .rst       (rst),
    .raw_we    (accept),
    .raw_waddr (pos_cnt),
    .raw_wdata (pixel_in),
    .raw_re    (accept),
    .raw_raddr (raw_raddr),
    .raw_rdata (right_pix),
    .fin_we    (s1_adv && s1_has_prev),
    .fin_waddr (s1_p),
    .fin_wdata (fin),
    .fin_re    (accept),
    .fin_raddr (pos_cnt),
    .fin_rdata (up_pix)
  );

  assign s1_adv = s1_valid && fifo_room;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix       <= pixel_in;
      s1_p         <= pos_cnt;
      s1_line      <= line_cnt;
      s1_has_prev  <= has_prev;
      s1_window    <= in_window;
      s1_last_line <= is_last_line;
      s1_last_pos  <= is_last_pos;
    end
    // this item's right neighbour is the next item's own raw value
    if (s1_adv) begin
      self_pix <= right_pix;
      left_pix <= fin;
    end
  end

  rcmf_median5 #(
    .W (PIXEL_BITS)
  ) u_median (
    .a   (up_pix),
    .b   (s1_pix),
    .c   (right_pix),
    .d   (left_pix),
    .e   (self_pix),
    .med (med)
  );

  assign fin        = s1_window ? med : self_pix;
  assign s1_pos_out = POS_W'(s1_p);
  assign s1_line_m1 = s1_line - LINE_W'(1);

  assign res_above = {fin, s1_line_m1, s1_pos_out, !s1_last_line, 1'b0};
  assign res_last  = {s1_pix, s1_line, s1_pos_out, 1'b1, s1_last_pos};
  assign push_a    = s1_adv && (s1_has_prev || s1_last_line);
  assign push_b    = s1_adv && s1_has_prev && s1_last_line;
  assign data_a    = s1_has_prev ? res_above : res_last;

  rcmf_result_fifo #(
    .W (RW)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_a    (push_a),
    .data_a    (data_a),
    .push_b    (push_b),
    .data_b    (res_last),
    .room      (fifo_room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign {pixel_out, line_index, position_index, end_of_run, end_of_frame} = out_data;

endmodule

`default_nettype wire

FILE: design/rcmf_cfg_regs.sv
// ----------------------------------------------------------------------------
// rcmf_cfg_regs
// APB register file holding the frame geometry and the filter window start.
// ----------------------------------------------------------------------------
`default_nettype none

module rcmf_cfg_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rcmf_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [rcmf_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [rcmf_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready,
  output rcmf_pkg::cfg_t                    cfg
);
  import rcmf_pkg::*;

  logic [REG_IDX_W-1:0] idx;
  logic                 wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[APB_ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.line_count              <= LINE_COUNT_RST;
      cfg.positions_per_line      <= POSITIONS_RST;
      cfg.first_filtered_line     <= FIRST_LINE_RST;
      cfg.first_filtered_position <= FIRST_POS_RST;
    end else if (wr_en) begin
      case (idx)
        REG_LINE_COUNT: cfg.line_count              <= pwdata[LINE_W-1:0];
        REG_POSITIONS:  cfg.positions_per_line      <= pwdata[PPL_W-1:0];
        REG_FIRST_LINE: cfg.first_filtered_line     <= pwdata[LINE_W-1:0];
        REG_FIRST_POS:  cfg.first_filtered_position <= pwdata[POS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_LINE_COUNT: prdata = APB_DATA_W'(cfg.line_count);
      REG_POSITIONS:  prdata = APB_DATA_W'(cfg.positions_per_line);
      REG_FIRST_LINE: prdata = APB_DATA_W'(cfg.first_filtered_line);
      REG_FIRST_POS:  prdata = APB_DATA_W'(cfg.first_filtered_position);
      default:        prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: design/rcmf_median5.sv
// ----------------------------------------------------------------------------
// rcmf_median5
// Median of five values by parallel ranking: each input is ranked against the
// other four with ties broken by input order, the one of middle rank wins.
// ----------------------------------------------------------------------------
`default_nettype none

module rcmf_median5 #(
  parameter int W = 8
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic [W-1:0] c,
  input  logic [W-1:0] d,
  input  logic [W-1:0] e,
  output logic [W-1:0] med
);
  localparam int N   = 5;
  localparam int MID = 2;

  logic [W-1:0] v    [N];
  logic [2:0]   rank [N];

  assign v[0] = a;
  assign v[1] = b;
  assign v[2] = c;
  assign v[3] = d;
  assign v[4] = e;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      rank[i] = '0;
      for (int j = 0; j < N; j++) begin
        if (j < i) begin
          if (v[j] <= v[i]) rank[i] = rank[i] + 3'd1;
        end else if (j > i) begin
          if (v[j] < v[i]) rank[i] = rank[i] + 3'd1;
        end
      end
    end
  end

  // ranks form a permutation, so exactly one input sits in the middle
  always_comb begin
    med = '0;
    for (int i = 0; i < N; i++) begin
      if (rank[i] == 3'(MID)) med = med | v[i];
    end
  end

endmodule

`default_nettype wire

FILE: design/rcmf_line_store.sv
// ----------------------------------------------------------------------------
// rcmf_line_store
// Two line memories: raw pixels of the arriving line and final pixels of the
// line above. One write and one registered read each; a read that hits the
// entry written in the same cycle returns the new data.
// ----------------------------------------------------------------------------
`default_nettype none

module rcmf_line_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int W     = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          raw_we,
  input  logic [AW-1:0] raw_waddr,
  input  logic [W-1:0]  raw_wdata,
  input  logic          raw_re,
  input  logic [AW-1:0] raw_raddr,
  output logic [W-1:0]  raw_rdata,
  input  logic          fin_we,
  input  logic [AW-1:0] fin_waddr,
  input  logic [W-1:0]  fin_wdata,
  input  logic          fin_re,
  input  logic [AW-1:0] fin_raddr,
  output logic [W-1:0]  fin_rdata
);

  logic [W-1:0] raw_mem [DEPTH];
  logic [W-1:0] fin_mem [DEPTH];

  logic [W-1:0] raw_q;
  logic [W-1:0] fin_q;
  logic [W-1:0] raw_byp;
  logic [W-1:0] fin_byp;
  logic         raw_hit;
  logic         fin_hit;

  always_ff @(posedge clk) begin
    if (raw_we) raw_mem[raw_waddr] <= raw_wdata;
    if (raw_re) begin
      raw_q   <= raw_mem[raw_raddr];
      raw_byp <= raw_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_we) fin_mem[fin_waddr] <= fin_wdata;
    if (fin_re) begin
      fin_q   <= fin_mem[fin_raddr];
      fin_byp <= fin_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_hit <= 1'b0;
      fin_hit <= 1'b0;
    end else begin
      if (raw_re) raw_hit <= raw_we && (raw_waddr == raw_raddr);
      if (fin_re) fin_hit <= fin_we && (fin_waddr == fin_raddr);
    end
  end

  assign raw_rdata = raw_hit ? raw_byp : raw_q;
  assign fin_rdata = fin_hit ? fin_byp : fin_q;

endmodule

`default_nettype wire

FILE: design/rcmf_result_fifo.sv
// ----------------------------------------------------------------------------
// rcmf_result_fifo
// Four-entry result queue taking up to two items per cycle and giving one.
// room is high while two free entries are guaranteed.
// ----------------------------------------------------------------------------
`default_nettype none

module rcmf_result_fifo #(
  parameter int W = 36
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push_a,
  input  logic [W-1:0] data_a,
  input  logic         push_b,
  input  logic [W-1:0] data_b,
  output logic         room,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);
  localparam int DEPTH = 4;

  logic [W-1:0] mem [DEPTH];
  logic [1:0]   wr_ptr;
  logic [1:0]   rd_ptr;
  logic [2:0]   count;
  logic [1:0]   n_push;
  logic         pop;

  assign n_push    = {1'b0, push_a} + {1'b0, push_b};
  assign out_valid = (count != 3'd0);
  assign pop       = out_valid && out_ready;
  assign room      = (count <= 3'(DEPTH - 2));
  assign out_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_a) mem[wr_ptr] <= data_a;
    if (push_b) mem[wr_ptr + 2'd1] <= data_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + n_push;
      rd_ptr <= rd_ptr + {1'b0, pop};
      count  <= count + {1'b0, n_push} - {2'b0, pop};
    end
  end

endmodule

`default_nettype wire

FILE: test/recursive_cross_median_filter_tb.sv
// ----------------------------------------------------------------------------
// recursive_cross_median_filter_tb
// Streams raster frames through the filter and checks every emitted pixel.
// A short table of hand-checked rows comes first: a 3x3 frame with both start
// registers written as zero, which act as one, then one-pixel frames. Random
// frames of many sizes and window settings follow, with the frame
// reprogrammed over the APB port between frames. A local model of the line
// buffers predicts each result that the table does not give. Register reads
// check the reset values and every write.

module recursive_cross_median_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rcmf_pkg::*;

  localparam int NPOS_MAX       = 1024;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int STALL_CYCLES   = 400;
  localparam int SETTLE_CYCLES  = 8;
  localparam int REPORT_MAX     = 10;

  typedef struct packed {
    logic [7:0]        pix;
    logic [LINE_W-1:0] line;
    logic [POS_W-1:0]  pos;
    logic              run;
    logic              frame;
  } pel_result_t;

  typedef enum logic [1:0] {ROW_WRITE, ROW_PIXEL} row_kind_t;

  // n_typed 0: results come from the line buffer model
  typedef struct packed {
    row_kind_t              kind;
    logic [REG_IDX_W-1:0]   reg_idx;
    logic [31:0]            data;
    logic [7:0]             pix;
    logic [1:0]             n_typed;
    pel_result_t            r0;
    pel_result_t            r1;
  } step_t;

  localparam pel_result_t NO_RES = '0;
  localparam step_t MODELED = '{ROW_PIXEL, REG_LINE_COUNT, 32'd0, 8'd0, 2'd0, NO_RES, NO_RES};

  localparam int DIRECTED_ROWS = 18;
  localparam step_t DIRECTED [DIRECTED_ROWS] = '{
    // 3x3 frame, start registers at zero act as one: only the center filters
    '{ROW_WRITE, REG_LINE_COUNT, 32'd3, 8'h00, 2'd0, NO_RES, NO_RES},
    '{ROW_WRITE, REG_POSITIONS,  32'd3, 8'h00, 2'd0, NO_RES, NO_RES},
    '{ROW_WRITE, REG_FIRST_LINE, 32'd0, 8'h00, 2'd0, NO_RES, NO_RES},
    '{ROW_WRITE, REG_FIRST_POS,  32'd0, 8'h00, 2'd0, NO_RES, NO_RES},
    '{ROW_PIXEL, REG_LINE_COUNT, 32'd0, 8'h00, 2'd0, NO_RES, NO_RES},
    '{ROW_PIXEL, REG_LINE_COUNT, 32'd0, 8'hFF, 2'd0, NO_RES, NO_RES},
    '{ROW_PIXEL, REG_LINE_COUNT, 32'd0, 8'h5A, 2'd0, NO_RES, NO_RES},
    '{ROW_PIXEL, REG_LINE_COUNT, 32'd0, 8'hA5, 2'd1, '{8'h00, 16'd0, 10'd0, 1'b1, 1'b0}, NO_RES},
    '{ROW_PIXEL, REG_LINE_COUNT, 32'd0, 8'h3C, 2'd1, '{8'hFF, 16'd0, 10'd1, 1'b1, 1'b0}, NO_RES},
    '{ROW_PIXEL, REG_LINE_COUNT, 32'd0, 8'hC3, 2'd1, '{8'h5A, 16'd0, 10'd2, 1'b1, 1'b0}, NO_RES},
    '{ROW_PIXEL, REG_LINE_COUNT, 32'd0, 8'h0F, 2'd2, '{8'hA5, 16'd1, 10'd0, 1'b0, 1'b0},
      '{8'h0F, 16'd2, 10'd0, 1'b1, 1'b0}},
    '{ROW_PIXEL, REG_LINE_COUNT, 32'd0, 8'hF0, 2'd0, NO_RES, NO_RES},
    '{ROW_PIXEL, REG_LINE_COUNT, 32'd0, 8'h81, 2'd2, '{8'hC3, 16'd1, 10'd2, 1'b0, 1'b0},
      '{8'h81, 16'd2, 10'd2, 1'b1, 1'b1}},
    // zero sizes act as a one-pixel frame: each item leaves at once
    '{ROW_WRITE, REG_LINE_COUNT, 32'd0, 8'h00, 2'd0, NO_RES, NO_RES},
    '{ROW_WRITE, REG_POSITIONS,  32'd0, 8'h00, 2'd0, NO_RES, NO_RES},
    '{ROW_PIXEL, REG_LINE_COUNT, 32'd0, 8'h12, 2'd1, '{8'h12, 16'd0, 10'd0, 1'b1, 1'b1}, NO_RES},
    '{ROW_PIXEL, REG_LINE_COUNT, 32'd0, 8'hED, 2'd1, '{8'hED, 16'd0, 10'd0, 1'b1, 1'b1}, NO_RES},
    '{ROW_PIXEL, REG_LINE_COUNT, 32'd0, 8'h00, 2'd1, '{8'h00, 16'd0, 10'd0, 1'b1, 1'b1}, NO_RES}
  };

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  psel     = 1'b0;
  logic                  penable  = 1'b0;
  logic                  pwrite   = 1'b0;
  logic [APB_ADDR_W-1:0] paddr    = '0;
  logic [APB_DATA_W-1:0] pwdata   = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [7:0]            pixel_in = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [7:0]            pixel_out;
  logic [LINE_W-1:0]     line_index;
  logic [POS_W-1:0]      position_index;
  logic                  end_of_run;
  logic                  end_of_frame;

  // line buffer model
  cfg_t        filt_cfg;
  logic [7:0]  upper_final [NPOS_MAX];
  logic [7:0]  row_mixed [NPOS_MAX];
  logic [7:0]  row_raw [NPOS_MAX];
  logic [31:0] line_ctr;
  logic [31:0] pos_ctr;

  pel_result_t due_pels [$];
  step_t       pixel_tags [$];
  int          errors       = 0;
  int          pixels_sent  = 0;
  int          snd_idle_pct = 0;
  int          rcv_idle_pct = 0;
  int          stall_reqs   = 0;
  int          stalls_done  = 0;
  int          hold_left    = 0;
  int          quiet_cycles = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  recursive_cross_median_filter u_top (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .pixel_in       (pixel_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .pixel_out      (pixel_out),
    .line_index     (line_index),
    .position_index (position_index),
    .end_of_run     (end_of_run),
    .end_of_frame   (end_of_frame)
  );

  function automatic logic [7:0] median5(input logic [7:0] a, b, c, d, e);
    logic [7:0] v [5];
    logic [7:0] t;
    v = '{a, b, c, d, e};
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4 - i; j++) begin
        if (v[j] > v[j+1]) begin
          t = v[j];
          v[j] = v[j+1];
          v[j+1] = t;
        end
      end
    end
    return v[2];
  endfunction

  function automatic void filter_pixel(input logic [7:0] pix, output int n,
                                       output pel_result_t ra, output pel_result_t rb);
    logic [31:0] lines, npos, start_line, start_pos, p, ln, li;
    logic        last_line, last_pos;
    logic [7:0]  fin;
    pel_result_t r [2];
    lines      = (filt_cfg.line_count == 0) ? 32'd1 : 32'(filt_cfg.line_count);
    npos       = (filt_cfg.positions_per_line == 0) ? 32'd1
                                                    : 32'(filt_cfg.positions_per_line);
    if (npos > NPOS_MAX) npos = NPOS_MAX;
    start_line = (filt_cfg.first_filtered_line == 0) ? 32'd1
                                                     : 32'(filt_cfg.first_filtered_line);
    start_pos  = (filt_cfg.first_filtered_position == 0) ? 32'd1
                                                         : 32'(filt_cfg.first_filtered_position);
    p         = pos_ctr;
    ln        = line_ctr;
    last_line = (ln >= lines - 1);
    last_pos  = (p >= npos - 1);
    n         = 0;
    r[0]      = NO_RES;
    r[1]      = NO_RES;
    row_raw[p] = pix;
    // finish the pixel above: left and upper neighbors are already final
    if (ln >= 1) begin
      li  = ln - 1;
      fin = row_mixed[p];
      if (li >= start_line && li + 1 < lines && p >= start_pos && p + 1 < npos)
        fin = median5(upper_final[p], pix, row_mixed[p+1], row_mixed[p-1], row_mixed[p]);
      row_mixed[p]   = fin;
      upper_final[p] = fin;
      r[0] = '{fin, li[LINE_W-1:0], p[POS_W-1:0], !last_line, 1'b0};
      n = 1;
    end
    if (last_line) begin
      r[n] = '{pix, ln[LINE_W-1:0], p[POS_W-1:0], 1'b1, last_pos};
      n++;
    end
    if (last_pos) begin
      row_mixed = row_raw;
      pos_ctr   = 0;
      line_ctr  = last_line ? 32'd0 : ((ln + 1) & 32'hFFFF);
    end else begin
      pos_ctr = p + 1;
    end
    ra = r[0];
    rb = r[1];
  endfunction

  task automatic note_error(input string what);
    errors++;
    if (errors <= REPORT_MAX) $display("%0t: %s", $time, what);
  endtask

  // monitor: predict on each accepted item, check each accepted result
  always @(posedge clk) begin : monitor
    step_t       tag;
    int          n;
    pel_result_t ra, rb, got, want;
    if (!rst && in_valid && in_ready) begin
      tag = (pixel_tags.size() != 0) ? pixel_tags.pop_front() : MODELED;
      filter_pixel(pixel_in, n, ra, rb);
      if (tag.n_typed != 0) begin
        n  = tag.n_typed;
        ra = tag.r0;
        rb = tag.r1;
      end
      if (n > 0) due_pels.push_back(ra);
      if (n > 1) due_pels.push_back(rb);
    end
    if (!rst && out_valid && out_ready) begin
      got = '{pixel_out, line_index, position_index, end_of_run, end_of_frame};
      if (due_pels.size() == 0) begin
        note_error($sformatf("unexpected pixel %02h line %0d pos %0d run %0b frame %0b",
                             got.pix, got.line, got.pos, got.run, got.frame));
      end else begin
        want = due_pels.pop_front();
        if (got != want)
          note_error($sformatf({"pixel mismatch: want %02h line %0d pos %0d run %0b ",
                                "frame %0b, got %02h line %0d pos %0d run %0b frame %0b"},
                               want.pix, want.line, want.pos, want.run, want.frame,
                               got.pix, got.line, got.pos, got.run, got.frame));
      end
    end
  end

  // receiver: random back-pressure, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (stalls_done != stall_reqs) begin
      stalls_done++;
      hold_left = STALL_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= (int'($urandom_range(99)) >= rcv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic cfg_read_check(input logic [REG_IDX_W-1:0] idx, input logic [31:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata != want)
      note_error($sformatf("register %0d reads %0h, want %0h", idx, prdata, want));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_LINE_COUNT: filt_cfg.line_count              = value[LINE_W-1:0];
      REG_POSITIONS:  filt_cfg.positions_per_line      = value[PPL_W-1:0];
      REG_FIRST_LINE: filt_cfg.first_filtered_line     = value[LINE_W-1:0];
      REG_FIRST_POS:  filt_cfg.first_filtered_position = value[POS_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_read_check(idx, value);
  endtask

  // drop valid, drain all due pixels, then let the pipeline settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (due_pels.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input int lines, input int ppl, input int ffl, input int ffp);
    wait_idle();
    cfg_write(REG_LINE_COUNT, lines);
    cfg_write(REG_POSITIONS, ppl);
    cfg_write(REG_FIRST_LINE, ffl);
    cfg_write(REG_FIRST_POS, ffp);
  endtask

  task automatic send_pixel(input logic [7:0] pix, input step_t tag);
    int gap;
    gap = 0;
    if (int'($urandom_range(99)) < snd_idle_pct) gap = $urandom_range(4, 1);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pixel_tags.push_back(tag);
    in_valid <= 1'b1;
    pixel_in <= pix;
    do @(posedge clk); while (!in_ready);
    pixels_sent++;
  endtask

  // uniform noise, a smooth level with impulses, or black and white only
  function automatic logic [7:0] pick_pixel(input int style, input int base);
    int v;
    case (style)
      0: v = $urandom_range(255);
      1: begin
        if ($urandom_range(9) == 0) v = $urandom_range(1) ? 255 : 0;
        else v = base + int'($urandom_range(16)) - 8;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
      end
      default: v = $urandom_range(1) ? 255 : 0;
    endcase
    return 8'(v);
  endfunction

  task automatic feed_lines(input int nlines, input int npos);
    int style, base;
    style = $urandom_range(2);
    base  = $urandom_range(255);
    for (int l = 0; l < nlines; l++)
      for (int x = 0; x < npos; x++)
        send_pixel(pick_pixel(style, base), MODELED);
  endtask

  task automatic random_frame();
    int lines, ppl, ffl, ffp;
    lines = $urandom_range(8, 3);
    ppl   = ($urandom_range(9) < 8) ? int'($urandom_range(12, 3)) : int'($urandom_range(64, 13));
    case ($urandom_range(9))
      0:       ffl = 0;
      1:       ffl = 65535;
      2:       ffl = lines - 2;
      default: ffl = $urandom_range(lines - 1, 1);
    endcase
    case ($urandom_range(9))
      0:       ffp = 0;
      1:       ffp = 1023;
      2:       ffp = ppl - 2;
      default: ffp = $urandom_range(ppl - 1, 1);
    endcase
    configure(lines, ppl, ffl, ffp);
    feed_lines(lines, ppl);
  endtask

  initial begin : main
    int ppl;
    filt_cfg     = '{LINE_COUNT_RST, POSITIONS_RST, FIRST_LINE_RST, FIRST_POS_RST};
    line_ctr     = 0;
    pos_ctr      = 0;
    snd_idle_pct = 34;
    rcv_idle_pct = 64;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    cfg_read_check(REG_LINE_COUNT, 32'(LINE_COUNT_RST));
    cfg_read_check(REG_POSITIONS, 32'(POSITIONS_RST));
    cfg_read_check(REG_FIRST_LINE, 32'(FIRST_LINE_RST));
    cfg_read_check(REG_FIRST_POS, 32'(FIRST_POS_RST));

    for (int k = 0; k < DIRECTED_ROWS; k++) begin
      if (DIRECTED[k].kind == ROW_WRITE) begin
        wait_idle();
        cfg_write(DIRECTED[k].reg_idx, DIRECTED[k].data);
      end else begin
        send_pixel(DIRECTED[k].pix, DIRECTED[k]);
      end
    end
    while (pixels_sent < 350) random_frame();

    wait_idle();
    snd_idle_pct = 64;
    rcv_idle_pct = 34;
    // open a frame of the largest height, then shorten it so line 3 is last
    ppl = $urandom_range(10, 3);
    configure(65535, ppl, 1, 1);
    feed_lines(3, ppl);
    wait_idle();
    cfg_write(REG_LINE_COUNT, 32'd4);
    feed_lines(1, ppl);
    while (pixels_sent < 700) random_frame();

    wait_idle();
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    // hold off the receiver while a full frame is offered
    configure(8, 12, 1, 1);
    stall_reqs++;
    feed_lines(8, 12);
    while (pixels_sent < 1050) random_frame();

    in_valid <= 1'b0;
    do @(posedge clk); while (due_pels.size() != 0);
    repeat (16) @(posedge clk);
    if (errors == 0 && due_pels.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
